FILE: src/iabf_pkg.sv
// Shared types and constants for the integer-to-ASCII base formatter.
// Used by iabf_digit_unit and integer_to_ascii_base_formatter; no dependencies.
package iabf_pkg;

  // Digit store sizing.
  localparam int unsigned DIGIT_STORE_DEPTH = 16;
  localparam int unsigned DIGIT_IDX_W       = $clog2(DIGIT_STORE_DEPTH);
  localparam int unsigned DIGIT_CNT_W       = $clog2(DIGIT_STORE_DEPTH + 1);

  // Field widths.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  // Conversion commands.
  localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OCT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UHEX = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PTR  = 3'd4;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;

  // Division by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT is exact for 32-bit x.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned QUOT10_W    = 64 - RECIP_SHIFT;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_PFX0,
    S_PFXX,
    S_SIGN,
    S_DIGIT
  } state_e;

  typedef struct packed {
    logic  mul_en;
    base_e base;
  } div_ctrl_t;

endpackage

FILE: src/iabf_digit_unit.sv
// Shared digit extraction unit: one quotient and remainder by the base per step.
// Depends on iabf_pkg. Base ten takes a registered reciprocal multiply first.
module iabf_digit_unit (
  input  logic                            clk_i,
  input  iabf_pkg::div_ctrl_t             ctrl_i,
  input  logic [iabf_pkg::VALUE_W-1:0]    work_i,
  output logic [iabf_pkg::VALUE_W-1:0]    quot_o,
  output logic [iabf_pkg::DIGIT_W-1:0]    digit_o
);

  logic [63:0]                     prod_q;
  logic [iabf_pkg::QUOT10_W-1:0]   q10;
  logic [32:0]                     tens;
  logic [32:0]                     rem10;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= work_i[31:0] * iabf_pkg::RECIP_TEN;
    end
  end

  assign q10   = prod_q[63:iabf_pkg::RECIP_SHIFT];
  assign tens  = {1'b0, q10, 3'b000} + {3'b000, q10, 1'b0};
  assign rem10 = {1'b0, work_i[31:0]} - tens;

  always_comb begin
    case (ctrl_i.base)
      iabf_pkg::BASE_OCT: begin
        quot_o  = {3'b000, work_i[iabf_pkg::VALUE_W-1:3]};
        digit_o = {1'b0, work_i[2:0]};
      end
      iabf_pkg::BASE_HEX: begin
        quot_o  = {4'b0000, work_i[iabf_pkg::VALUE_W-1:4]};
        digit_o = work_i[3:0];
      end
      default: begin
        quot_o  = {{(iabf_pkg::VALUE_W - iabf_pkg::QUOT10_W){1'b0}}, q10};
        digit_o = rem10[3:0];
      end
    endcase
  end

endmodule

FILE: src/integer_to_ascii_base_formatter.sv
// Top level of the integer-to-ASCII base formatter.
// Depends on iabf_pkg and iabf_digit_unit.

// One input beat carries a 64-bit value and a command: 0 signed decimal, 1 unsigned
// decimal, 2 octal and 3 uppercase hexadecimal of the low 32 bits, 4 a 64-bit pointer
// printed as lowercase hexadecimal after "0x". Commands 5 to 7 are taken and produce
// nothing. The block answers with one output beat per character, most significant
// first, with last set on the final one; zero prints as a single "0". Work is done one
// number at a time: in_stall_o is high from the accepting edge until the last character
// has been loaded into the output register. Digits come from one shared divide unit,
// least significant first. Octal and hexadecimal give one digit per divide step;
// decimal takes a registered reciprocal multiply, then the remainder correction. The
// characters then leave at one per cycle when the output is not stalled. The output
// register lets the next number be accepted while the final character still waits.
module integer_to_ascii_base_formatter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [iabf_pkg::VALUE_W-1:0]   value_i,
  input  logic [iabf_pkg::CMD_W-1:0]     command_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [iabf_pkg::CHAR_W-1:0]    ascii_char_o,
  output logic                           last_o
);

  iabf_pkg::state_e                      state_q, state_d;
  iabf_pkg::base_e                       base_q, base_in;
  logic                                  cmd_ok;
  logic                                  upper_q, ptr_q, neg_q;
  logic [iabf_pkg::VALUE_W-1:0]          work_q;
  logic [iabf_pkg::DIGIT_CNT_W-1:0]      count_q;
  logic [iabf_pkg::DIGIT_W-1:0]          store_q [iabf_pkg::DIGIT_STORE_DEPTH];

  iabf_pkg::div_ctrl_t                   div_ctrl;
  logic [iabf_pkg::VALUE_W-1:0]          quot;
  logic [iabf_pkg::DIGIT_W-1:0]          digit;
  logic                                  step_done, quot_zero;
  iabf_pkg::state_e                      emit_first;

  logic                                  emitting, load;
  logic [iabf_pkg::DIGIT_IDX_W-1:0]      rd_idx;
  logic [iabf_pkg::DIGIT_CNT_W-1:0]      cnt_m1;
  logic [iabf_pkg::DIGIT_W-1:0]          rd_digit;
  logic [iabf_pkg::CHAR_W-1:0]           char_d, char_q;
  logic                                  last_d, last_q, out_valid_q;
  logic                                  in_acc;

  // Command decode; unused codes are taken and dropped.
  always_comb begin
    cmd_ok  = 1'b1;
    base_in = iabf_pkg::BASE_DEC;
    unique case (command_i) inside
      iabf_pkg::CMD_SDEC, iabf_pkg::CMD_UDEC: base_in = iabf_pkg::BASE_DEC;
      iabf_pkg::CMD_OCT:                      base_in = iabf_pkg::BASE_OCT;
      iabf_pkg::CMD_UHEX, iabf_pkg::CMD_PTR:  base_in = iabf_pkg::BASE_HEX;
      default:                                cmd_ok  = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != iabf_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // The shared divide unit. For base ten the multiply is registered in S_DIV and
  // the quotient and remainder are formed in S_FIX.
  assign div_ctrl.mul_en = (state_q == iabf_pkg::S_DIV);
  assign div_ctrl.base   = base_q;

  iabf_digit_unit u_digit_unit (
    .clk_i   (clk_i),
    .ctrl_i  (div_ctrl),
    .work_i  (work_q),
    .quot_o  (quot),
    .digit_o (digit)
  );

  assign step_done = ((state_q == iabf_pkg::S_DIV) && (base_q != iabf_pkg::BASE_DEC))
                     || (state_q == iabf_pkg::S_FIX);
  assign quot_zero = (quot == '0);
  assign emit_first = ptr_q ? iabf_pkg::S_PFX0
                    : (neg_q ? iabf_pkg::S_SIGN : iabf_pkg::S_DIGIT);

  // A character may be loaded whenever the output register is empty or draining.
  assign emitting = (state_q == iabf_pkg::S_PFX0) || (state_q == iabf_pkg::S_PFXX)
                    || (state_q == iabf_pkg::S_SIGN) || (state_q == iabf_pkg::S_DIGIT);
  assign load     = emitting && (!out_valid_q || !out_stall_i);

  // The digit count doubles as the read pointer while digits go out.
  assign cnt_m1   = count_q - 1'b1;
  assign rd_idx   = cnt_m1[iabf_pkg::DIGIT_IDX_W-1:0];
  assign rd_digit = store_q[rd_idx];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iabf_pkg::S_IDLE: begin
        if (in_acc && cmd_ok) state_d = iabf_pkg::S_DIV;
      end
      iabf_pkg::S_DIV: begin
        if (base_q == iabf_pkg::BASE_DEC) state_d = iabf_pkg::S_FIX;
        else if (quot_zero)               state_d = emit_first;
      end
      iabf_pkg::S_FIX: begin
        state_d = quot_zero ? emit_first : iabf_pkg::S_DIV;
      end
      iabf_pkg::S_PFX0: begin
        if (load) state_d = iabf_pkg::S_PFXX;
      end
      iabf_pkg::S_PFXX: begin
        if (load) state_d = neg_q ? iabf_pkg::S_SIGN : iabf_pkg::S_DIGIT;
      end
      iabf_pkg::S_SIGN: begin
        if (load) state_d = iabf_pkg::S_DIGIT;
      end
      iabf_pkg::S_DIGIT: begin
        if (load && (count_q == iabf_pkg::DIGIT_CNT_W'(1))) state_d = iabf_pkg::S_IDLE;
      end
      default: state_d = iabf_pkg::S_IDLE;
    endcase
  end

  // Character selection for the output register.
  always_comb begin
    char_d = iabf_pkg::CHAR_ZERO;
    last_d = 1'b0;
    unique case (state_q)
      iabf_pkg::S_PFX0: char_d = iabf_pkg::CHAR_ZERO;
      iabf_pkg::S_PFXX: char_d = iabf_pkg::CHAR_X;
      iabf_pkg::S_SIGN: char_d = iabf_pkg::CHAR_MINUS;
      iabf_pkg::S_DIGIT: begin
        if (rd_digit < 4'd10) begin
          char_d = iabf_pkg::CHAR_ZERO + {4'b0000, rd_digit};
        end else begin
          char_d = (upper_q ? iabf_pkg::CHAR_UPPER_A : iabf_pkg::CHAR_LOWER_A)
                   + {4'b0000, rd_digit} - 8'd10;
        end
        last_d = (count_q == iabf_pkg::DIGIT_CNT_W'(1));
      end
      default: begin
        char_d = iabf_pkg::CHAR_ZERO;
        last_d = 1'b0;
      end
    endcase
  end

  // Control and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iabf_pkg::S_IDLE;
      work_q  <= '0;
      count_q <= '0;
      neg_q   <= 1'b0;
      base_q  <= iabf_pkg::BASE_DEC;
      upper_q <= 1'b0;
      ptr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && cmd_ok) begin
        base_q  <= base_in;
        upper_q <= (command_i == iabf_pkg::CMD_UHEX);
        ptr_q   <= (command_i == iabf_pkg::CMD_PTR);
        count_q <= '0;
        if (command_i == iabf_pkg::CMD_PTR) begin
          work_q <= value_i;
          neg_q  <= 1'b0;
        end else if ((command_i == iabf_pkg::CMD_SDEC) && value_i[31]) begin
          // Two's complement magnitude; the most negative value maps to 2^31.
          work_q <= {32'd0, 32'd0 - value_i[31:0]};
          neg_q  <= 1'b1;
        end else begin
          work_q <= {32'd0, value_i[31:0]};
          neg_q  <= 1'b0;
        end
      end else if (step_done) begin
        work_q <= quot;
        if (count_q < iabf_pkg::DIGIT_CNT_W'(iabf_pkg::DIGIT_STORE_DEPTH)) begin
          count_q <= count_q + 1'b1;
        end
      end else if (load && (state_q == iabf_pkg::S_DIGIT)) begin
        count_q <= cnt_m1;
      end
    end
  end

  // Digit store: written least significant first, no reset.
  always_ff @(posedge clk_i) begin
    if (step_done
        && (count_q < iabf_pkg::DIGIT_CNT_W'(iabf_pkg::DIGIT_STORE_DEPTH))) begin
      store_q[count_q[iabf_pkg::DIGIT_IDX_W-1:0]] <= digit;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

  // The multiply phase always comes straight before the correction phase.
  a_fix_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iabf_pkg::S_FIX) |-> ($past(state_q) == iabf_pkg::S_DIV))
    else $error("correction step without a preceding multiply step");

  // Digits are never sent from an empty store.
  a_digit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iabf_pkg::S_DIGIT) |-> (count_q != '0))
    else $error("digit emission with an empty digit store");

  // The count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iabf_pkg::DIGIT_CNT_W'(iabf_pkg::DIGIT_STORE_DEPTH))
    else $error("digit count beyond store depth");

  // Loading the final character returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> (state_q == iabf_pkg::S_IDLE))
    else $error("final character loaded but block not idle");

  // Only the final digit of a number carries last.
  a_last_only_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |-> (state_q == iabf_pkg::S_DIGIT))
    else $error("last flag on a non-digit character");

endmodule
